// ===== src/square_window_min_filter_unit_assert.svh =====
// Assertion macros shared by the square window minimum filter RTL.
`ifndef SQUARE_WINDOW_MIN_FILTER_UNIT_ASSERT_SVH
`define SQUARE_WINDOW_MIN_FILTER_UNIT_ASSERT_SVH

// Assert a property on the given clock, disabled while the given reset is low.
`define SWMF_ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Assert a property on the default clock and reset of the module.
`define SWMF_ASSERT(lbl, prop, msg) `SWMF_ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== src/swmf_pkg.sv =====
// Shared constants, payload types and helpers of the square window minimum filter.
package swmf_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;
  localparam int MAX_RADIUS = 16;

  localparam int CFG_W    = 12;
  localparam int CFG_IDX_W = 2;
  localparam int PIX_W    = 8;
  localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WVAL_W = $clog2(MAX_WIDTH + 1);
  localparam int HVAL_W = $clog2(MAX_HEIGHT + 1);
  localparam int ROW_W  = $clog2(MAX_HEIGHT + MAX_RADIUS + 2);
  localparam int RAD_W  = $clog2(MAX_RADIUS + 1);
  localparam int SUM_W  = $clog2(MAX_WIDTH + 2 * MAX_RADIUS + 2);
  localparam int POS_W  = $clog2(MAX_WIDTH * (MAX_HEIGHT + MAX_RADIUS + 1) + MAX_RADIUS + 1);

  localparam int NCELL = 2 * MAX_RADIUS;
  localparam int NV    = 2 * MAX_RADIUS + 1;
  localparam int NG    = (NV + 3) / 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH   = 2'd0,
    CFG_FRAME_HEIGHT  = 2'd1,
    CFG_WINDOW_RADIUS = 2'd2
  } cfg_index_e;

  typedef struct packed {
    logic             operation;
    logic [PIX_W-1:0] pixel;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] min_value;
    logic             row_end;
    logic             frame_end;
  } out_item_t;

  function automatic logic [PIX_W-1:0] min8(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage

// ===== src/square_window_min_filter_unit.sv =====
// Top level of the square window minimum filter (grayscale erosion).
//
// Pixels enter in raster order on the in channel (valid/stall); a transfer
// with operation 0 carries a real pixel, operation 1 a drain tick. After the
// last real pixel of a frame, R*W+R further transfers (drain ticks) flush the
// final rows and columns. Each transfer gives at most one result on the out
// channel, flagged with row_end and frame_end; results start R*W+R raster
// positions after the first pixel. A drain tick sent early is dropped.
// The cfg channel (valid/ready, always ready) sets width, height and radius
// and restarts the frame; write it only while the block is idle.
// Throughput: one transfer per clock while in_stall_o is low. The line
// store is read at the transfer edge, then come two levels of the vertical
// minimum tree, the window shift and two levels of the horizontal minimum
// tree, the last level feeding the output register. The line store is a
// chain of 2*MAX_RADIUS row memories read in parallel, so every pixel
// advances all rows at once. An output register and a skid stage part the
// two sides: when the receiver stalls, results collect there and stall is
// raised toward the sender only once both are full. Reset clears counters,
// window and handshake state; the line store needs no clearing pass, since
// rows are read only once written.
`include "square_window_min_filter_unit_assert.svh"

module square_window_min_filter_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  swmf_pkg::in_item_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output swmf_pkg::out_item_t            out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [swmf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [swmf_pkg::CFG_W-1:0]     cfg_data_i
);
  import swmf_pkg::*;

  typedef struct packed {
    logic          emit;
    logic          rend;
    logic          fend;
    logic [NV-1:0] hmask;
  } tag_t;

  function automatic logic [WVAL_W-1:0] clamp_w(logic [CFG_W-1:0] v);
    if (v == '0) return WVAL_W'(1);
    if (int'(v) > MAX_WIDTH) return WVAL_W'(MAX_WIDTH);
    return WVAL_W'(v);
  endfunction

  function automatic logic [HVAL_W-1:0] clamp_h(logic [CFG_W-1:0] v);
    if (v == '0) return HVAL_W'(1);
    if (int'(v) > MAX_HEIGHT) return HVAL_W'(MAX_HEIGHT);
    return HVAL_W'(v);
  endfunction

  function automatic logic [RAD_W-1:0] clamp_r(logic [4:0] v);
    if (int'(v) > MAX_RADIUS) return RAD_W'(MAX_RADIUS);
    return RAD_W'(v);
  endfunction

  function automatic logic [POS_W-1:0] lag_of(logic [RAD_W-1:0] r, logic [WVAL_W-1:0] w);
    return POS_W'(r) * POS_W'(w) + POS_W'(r);
  endfunction

  // ---------------- configuration ----------------
  logic [WVAL_W-1:0] w_q, w_d;
  logic [HVAL_W-1:0] h_q, h_d;
  logic [RAD_W-1:0]  r_q, r_d;
  logic [POS_W-1:0]  lag_q;
  logic              cfg_restart;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    w_d = w_q;
    h_d = h_q;
    r_d = r_q;
    cfg_restart = 1'b0;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_FRAME_WIDTH: begin
          w_d = clamp_w(cfg_data_i);
          cfg_restart = 1'b1;
        end
        CFG_FRAME_HEIGHT: begin
          h_d = clamp_h(cfg_data_i);
          cfg_restart = 1'b1;
        end
        CFG_WINDOW_RADIUS: begin
          r_d = clamp_r(cfg_data_i[4:0]);
          cfg_restart = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q   <= WVAL_W'(640);
      h_q   <= HVAL_W'(480);
      r_q   <= RAD_W'(15);
      lag_q <= POS_W'(15 * 640 + 15);
    end else if (cfg_restart) begin
      w_q   <= w_d;
      h_q   <= h_d;
      r_q   <= r_d;
      lag_q <= lag_of(r_d, w_d);
    end
  end

  // ---------------- input stage: counters and masks ----------------
  logic adv;
  logic skid_valid_q;

  logic [COL_W-1:0] in_col_q;
  logic [ROW_W-1:0] in_row_q;
  logic [POS_W-1:0] pos_q;
  logic [COL_W-1:0] oc_q;
  logic [ROW_W-1:0] orow_q;

  logic             acc, drain_row, proc, last_col_in;
  logic [PIX_W-1:0] px0;
  tag_t             tag0;
  logic [NCELL-1:0] rmask0;

  assign adv        = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  assign acc         = in_valid_i && !in_stall_o;
  assign drain_row   = in_row_q >= ROW_W'(h_q);
  assign proc        = acc && (drain_row || !in_data_i.operation);
  assign px0         = drain_row ? PIX_MAX : in_data_i.pixel;
  assign last_col_in = WVAL_W'(in_col_q) == (w_q - 1'b1);

  always_comb begin
    tag0.emit = pos_q >= lag_q;
    tag0.rend = tag0.emit && (WVAL_W'(oc_q) == (w_q - 1'b1));
    tag0.fend = tag0.rend && (orow_q == (ROW_W'(h_q) - 1'b1));
    for (int a = 0; a < NV; a++) begin
      tag0.hmask[a] = (a <= 2 * int'(r_q))
                   && (SUM_W'(a) <= SUM_W'(oc_q) + SUM_W'(r_q))
                   && (SUM_W'(a) + SUM_W'(w_q) > SUM_W'(oc_q) + SUM_W'(r_q));
    end
    for (int k = 0; k < NCELL; k++) begin
      rmask0[k] = (int'(in_row_q) >= k + 1) && (k + 1 <= 2 * int'(r_q));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q <= '0;
      in_row_q <= '0;
      pos_q    <= '0;
      oc_q     <= '0;
      orow_q   <= '0;
    end else if (cfg_restart || (proc && tag0.fend)) begin
      in_col_q <= '0;
      in_row_q <= '0;
      pos_q    <= '0;
      oc_q     <= '0;
      orow_q   <= '0;
    end else if (proc) begin
      pos_q <= pos_q + 1'b1;
      if (last_col_in) begin
        in_col_q <= '0;
        in_row_q <= in_row_q + 1'b1;
      end else begin
        in_col_q <= in_col_q + 1'b1;
      end
      if (tag0.emit) begin
        if (tag0.rend) begin
          oc_q   <= '0;
          orow_q <= orow_q + 1'b1;
        end else begin
          oc_q <= oc_q + 1'b1;
        end
      end
    end
  end

  // ---------------- pipeline valid bits ----------------
  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q, s5_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= proc;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
      s5_valid_q <= s4_valid_q;
    end
  end

  // ---------------- stage 1: line store chain ----------------
  logic [PIX_W-1:0] s1_px_q;
  logic [COL_W-1:0] s1_col_q;
  logic [NCELL-1:0] s1_rmask_q;
  tag_t             s1_tag_q;
  logic [PIX_W-1:0] dout [NCELL];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_px_q    <= px0;
      s1_col_q   <= in_col_q;
      s1_rmask_q <= rmask0;
      s1_tag_q   <= tag0;
    end
  end

  for (genvar k = 0; k < NCELL; k++) begin : g_line
    logic [PIX_W-1:0] wdata;
    if (k == 0) begin : g_head
      assign wdata = s1_px_q;
    end else begin : g_body
      assign wdata = dout[k-1];
    end
    swmf_line_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .raddr_i (in_col_q),
      .we_i    (adv && s1_valid_q),
      .waddr_i (s1_col_q),
      .wdata_i (wdata),
      .rdata_o (dout[k])
    );
  end

  // ---------------- stages 2, 3: vertical minimum tree ----------------
  logic [PIX_W-1:0] vvals  [NG*4];
  logic [PIX_W-1:0] s2_grp_q [NG];
  tag_t             s2_tag_q;
  logic [PIX_W-1:0] vmin2;
  logic [PIX_W-1:0] s3_vmin_q;
  tag_t             s3_tag_q;

  always_comb begin
    for (int i = 0; i < NG * 4; i++) begin
      vvals[i] = PIX_MAX;
    end
    vvals[0] = s1_px_q;
    for (int k = 0; k < NCELL; k++) begin
      vvals[k+1] = s1_rmask_q[k] ? dout[k] : PIX_MAX;
    end
    vmin2 = PIX_MAX;
    for (int g = 0; g < NG; g++) begin
      vmin2 = min8(vmin2, s2_grp_q[g]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int g = 0; g < NG; g++) begin
        s2_grp_q[g] <= min8(min8(vvals[4*g], vvals[4*g+1]),
                            min8(vvals[4*g+2], vvals[4*g+3]));
      end
      s2_tag_q  <= s1_tag_q;
      s3_vmin_q <= vmin2;
      s3_tag_q  <= s2_tag_q;
    end
  end

  // ---------------- stage 4: horizontal window chain ----------------
  tag_t             s4_tag_q;
  logic [PIX_W-1:0] win [NV];
  logic             win_clr;

  // Clear after the frame-end item has shifted in; the next item may load at once.
  assign win_clr = (adv && s4_valid_q && s4_tag_q.fend) || cfg_restart;

  for (genvar a = 0; a < NV; a++) begin : g_win
    logic [PIX_W-1:0] din;
    if (a == 0) begin : g_head
      assign din = s3_vmin_q;
    end else begin : g_body
      assign din = win_clr ? PIX_MAX : win[a-1];
    end
    swmf_win_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .load_i (adv && s3_valid_q),
      .clr_i  (win_clr),
      .din_i  (din),
      .val_o  (win[a])
    );
  end

  // ---------------- stages 5, 6: horizontal minimum tree ----------------
  logic [PIX_W-1:0] hvals [NG*4];
  logic [PIX_W-1:0] s5_grp_q [NG];
  tag_t             s5_tag_q;
  logic [PIX_W-1:0] res_min;
  logic             res_valid;
  out_item_t        res;

  always_comb begin
    for (int i = 0; i < NG * 4; i++) begin
      hvals[i] = PIX_MAX;
    end
    for (int a = 0; a < NV; a++) begin
      hvals[a] = s4_tag_q.hmask[a] ? win[a] : PIX_MAX;
    end
    res_min = PIX_MAX;
    for (int g = 0; g < NG; g++) begin
      res_min = min8(res_min, s5_grp_q[g]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_tag_q <= s3_tag_q;
      for (int g = 0; g < NG; g++) begin
        s5_grp_q[g] <= min8(min8(hvals[4*g], hvals[4*g+1]),
                            min8(hvals[4*g+2], hvals[4*g+3]));
      end
      s5_tag_q <= s4_tag_q;
    end
  end

  assign res_valid     = adv && s5_valid_q && s5_tag_q.emit;
  assign res.min_value = res_min;
  assign res.row_end   = s5_tag_q.rend;
  assign res.frame_end = s5_tag_q.fend;

  // ---------------- output register and skid stage ----------------
  logic      out_valid_q, pop;
  out_item_t out_q, skid_q;

  assign pop = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (res_valid) begin
      if (out_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (res_valid) begin
      if (out_valid_q && !pop) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------- assertions ----------------
  `SWMF_ASSERT(a_skid_behind_out, skid_valid_q |-> out_valid_q, "skid holds data while output register is empty")
  `SWMF_ASSERT(a_skid_drains, skid_valid_q && !out_stall_i |=> !skid_valid_q, "skid did not drain after output transfer")
  `SWMF_ASSERT(a_fend_on_rend, out_valid_o && out_data_o.frame_end |-> out_data_o.row_end, "frame end without row end")
  `SWMF_ASSERT(a_col_in_frame, WVAL_W'(in_col_q) < w_q, "input column beyond frame width")

endmodule

// ===== src/swmf_line_cell.sv =====
// One line store row of the vertical chain: byte memory with write forwarding.
module swmf_line_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic [swmf_pkg::COL_W-1:0] raddr_i,
  input  logic                       we_i,
  input  logic [swmf_pkg::COL_W-1:0] waddr_i,
  input  logic [swmf_pkg::PIX_W-1:0] wdata_i,
  output logic [swmf_pkg::PIX_W-1:0] rdata_o
);
  import swmf_pkg::*;

  logic [PIX_W-1:0] mem [MAX_WIDTH];
  logic [PIX_W-1:0] rd_q;
  logic [PIX_W-1:0] fwd_data_q;
  logic             fwd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (en_i) begin
      rd_q       <= mem[raddr_i];
      fwd_data_q <= wdata_i;
    end
  end

  // Take the written byte when the same column is read at the write edge.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (en_i) begin
      fwd_q <= we_i && (waddr_i == raddr_i);
    end
  end

  assign rdata_o = fwd_q ? fwd_data_q : rd_q;

endmodule

// ===== src/swmf_win_cell.sv =====
// One column minimum cell of the horizontal window shift chain.
module swmf_win_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       load_i,
  input  logic                       clr_i,
  input  logic [swmf_pkg::PIX_W-1:0] din_i,
  output logic [swmf_pkg::PIX_W-1:0] val_o
);
  import swmf_pkg::*;

  logic [PIX_W-1:0] val_q;

  // Shift in the neighbor value; restart the frame to all white.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= PIX_MAX;
    end else if (load_i) begin
      val_q <= din_i;
    end else if (clr_i) begin
      val_q <= PIX_MAX;
    end
  end

  assign val_o = val_q;

endmodule
